@@ rtl/hsd_pkg.sv @@
// ----------------------------------------------------------------------------
// hsd_pkg
// shared types, constants and helpers of the heap sift-down core
// ----------------------------------------------------------------------------
`default_nettype none

package hsd_pkg;

  localparam int unsigned DEPTH_DEF      = 1024;
  localparam int unsigned ELEM_WIDTH_DEF = 32;

  localparam int unsigned IDX_W  = 10;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned SIZE_W = 11;
  localparam int unsigned CNT_W  = 32;

  // request codes
  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_SIFT  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  // heap ordering
  typedef enum logic {
    ORDER_MAX = 1'b0,
    ORDER_MIN = 1'b1
  } order_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RD_WAIT,
    ST_SIFT_LD,
    ST_SIFT_RD,
    ST_SIFT_CMP,
    ST_RESP
  } state_e;

  // one result beat
  typedef struct packed {
    logic signed [VAL_W-1:0] read_data;
    logic [CNT_W-1:0]        swaps;
    logic [CNT_W-1:0]        compares;
  } rsp_t;

  localparam logic [CNT_W-1:0] CMP_PER_LEVEL = CNT_W'(3);
  localparam logic [CNT_W-1:0] SWAP_INC      = CNT_W'(1);

  // saturating counter add
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] cnt,
                                               input logic [CNT_W-1:0] inc);
    logic [CNT_W:0] sum;
    sum = {1'b0, cnt} + {1'b0, inc};
    return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/hsd_mem.sv @@
// ----------------------------------------------------------------------------
// hsd_mem
// element store: one write port, two read ports, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module hsd_mem import hsd_pkg::*; #(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned ELEM_WIDTH = ELEM_WIDTH_DEF,
  localparam int unsigned AW        = $clog2(DEPTH)
) (
  input  wire logic                  clk_i,
  input  wire logic                  we_i,
  input  wire logic [AW-1:0]         waddr_i,
  input  wire logic [ELEM_WIDTH-1:0] wdata_i,
  input  wire logic                  ra_en_i,
  input  wire logic [AW-1:0]         ra_addr_i,
  output logic      [ELEM_WIDTH-1:0] ra_data_o,
  input  wire logic                  rb_en_i,
  input  wire logic [AW-1:0]         rb_addr_i,
  output logic      [ELEM_WIDTH-1:0] rb_data_o
);

  logic [ELEM_WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ra_en_i) begin
      ra_data_o <= mem_q[ra_addr_i];
    end
    if (rb_en_i) begin
      rb_data_o <= mem_q[rb_addr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/hsd_ctrl.sv @@
// ----------------------------------------------------------------------------
// hsd_ctrl
// request sequencer: write, read, counter clear and level-by-level sift-down
// ----------------------------------------------------------------------------
`default_nettype none

module hsd_ctrl import hsd_pkg::*; #(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned ELEM_WIDTH = ELEM_WIDTH_DEF,
  localparam int unsigned AW        = $clog2(DEPTH)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic        [1:0]            req_type_i,
  input  wire logic        [IDX_W-1:0]      index_i,
  input  wire logic signed [VAL_W-1:0]      value_i,
  input  wire logic        [SIZE_W-1:0]     heap_size_i,
  input  wire logic                         heap_order_i,
  output logic                              rsp_valid_o,
  input  wire logic                         rsp_ready_i,
  output rsp_t                              rsp_o,
  output logic                              we_o,
  output logic             [AW-1:0]         waddr_o,
  output logic             [ELEM_WIDTH-1:0] wdata_o,
  output logic                              ra_en_o,
  output logic             [AW-1:0]         ra_addr_o,
  input  wire logic signed [ELEM_WIDTH-1:0] ra_data_i,
  output logic                              rb_en_o,
  output logic             [AW-1:0]         rb_addr_o,
  input  wire logic signed [ELEM_WIDTH-1:0] rb_data_i
);

  localparam int unsigned NW  = (AW > IDX_W) ? AW : IDX_W;
  localparam int unsigned CHW = NW + 2;
  localparam int unsigned SZW = ((AW + 1) > SIZE_W) ? (AW + 1) : SIZE_W;

  state_e state_q, state_d;
  req_e   req_q, req_d;

  logic        [IDX_W-1:0]      idx_q, idx_d;
  logic signed [VAL_W-1:0]      val_q, val_d;
  logic        [SZW-1:0]        size_q, size_d;
  logic        [NW-1:0]         node_q, node_d;
  logic signed [ELEM_WIDTH-1:0] carry_q, carry_d;
  logic                         moved_q, moved_d;
  logic signed [VAL_W-1:0]      rdata_q, rdata_d;
  logic        [CNT_W-1:0]      swp_q, swp_d;
  logic        [CNT_W-1:0]      cmp_q, cmp_d;

  logic [SZW-1:0] size_ext;
  logic [SZW-1:0] size_clamp;
  logic [CHW-1:0] idx_w;
  logic           idx_in_range;
  logic [CHW-1:0] node_w;
  logic [CHW-1:0] left_w;
  logic [CHW-1:0] right_w;
  logic           left_ok;
  logic           right_ok;
  logic           l_take;
  logic           r_take;
  logic           swap;
  logic signed [ELEM_WIDTH-1:0] best_val;
  logic signed [ELEM_WIDTH-1:0] sel_val;
  logic [CHW-1:0] sel_w;

  assign size_ext   = SZW'(heap_size_i);
  assign size_clamp = (size_ext > SZW'(DEPTH)) ? SZW'(DEPTH) : size_ext;

  assign idx_w        = CHW'(idx_q);
  assign idx_in_range = idx_w < CHW'(DEPTH);

  // children of the current node
  assign node_w   = CHW'(node_q);
  assign left_w   = (node_w << 1) + CHW'(1);
  assign right_w  = left_w + CHW'(1);
  assign left_ok  = left_w < CHW'(size_q);
  assign right_ok = right_w < CHW'(size_q);

  // the node position logically holds the carried element
  assign l_take   = left_ok && ((heap_order_i == ORDER_MIN) ? (ra_data_i < carry_q)
                                                            : (ra_data_i > carry_q));
  assign best_val = l_take ? ra_data_i : carry_q;
  assign r_take   = right_ok && ((heap_order_i == ORDER_MIN) ? (rb_data_i < best_val)
                                                             : (rb_data_i > best_val));
  assign swap     = l_take || r_take;
  assign sel_val  = r_take ? rb_data_i : ra_data_i;
  assign sel_w    = r_take ? right_w : left_w;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (req_q)
          REQ_WRITE: state_d = ST_RESP;
          REQ_READ:  state_d = ST_RD_WAIT;
          REQ_SIFT:  state_d = ST_SIFT_LD;
          REQ_CLEAR: state_d = ST_RESP;
          default:   state_d = ST_RESP;
        endcase
      end
      ST_RD_WAIT:  state_d = ST_RESP;
      ST_SIFT_LD:  state_d = ST_SIFT_CMP;
      ST_SIFT_RD:  state_d = ST_SIFT_CMP;
      ST_SIFT_CMP: state_d = swap ? ST_SIFT_RD : ST_RESP;
      ST_RESP: begin
        if (rsp_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = 1'b0;
    rsp_valid_o = 1'b0;
    we_o        = 1'b0;
    waddr_o     = node_q[AW-1:0];
    wdata_o     = carry_q;
    ra_en_o     = 1'b0;
    ra_addr_o   = idx_w[AW-1:0];
    rb_en_o     = 1'b0;
    rb_addr_o   = right_w[AW-1:0];
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_EXEC: begin
        if (req_q == REQ_WRITE) begin
          we_o    = idx_in_range;
          waddr_o = idx_w[AW-1:0];
          wdata_o = ELEM_WIDTH'(val_q);
        end
        ra_en_o = (req_q == REQ_READ) || (req_q == REQ_SIFT);
      end
      ST_SIFT_LD, ST_SIFT_RD: begin
        ra_en_o   = 1'b1;
        ra_addr_o = left_w[AW-1:0];
        rb_en_o   = 1'b1;
      end
      ST_SIFT_CMP: begin
        // child moves up now, carried element lands once the walk stops
        we_o    = swap || moved_q;
        wdata_o = swap ? sel_val : carry_q;
      end
      ST_RESP: rsp_valid_o = 1'b1;
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    req_d   = req_q;
    idx_d   = idx_q;
    val_d   = val_q;
    size_d  = size_q;
    node_d  = node_q;
    carry_d = carry_q;
    moved_d = moved_q;
    rdata_d = rdata_q;
    swp_d   = swp_q;
    cmp_d   = cmp_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d   = req_e'(req_type_i);
          idx_d   = index_i;
          val_d   = value_i;
          size_d  = size_clamp;
          node_d  = NW'(index_i);
          moved_d = 1'b0;
          rdata_d = '0;
        end
      end
      ST_EXEC: begin
        if (req_q == REQ_CLEAR) begin
          swp_d = '0;
          cmp_d = '0;
        end
      end
      ST_RD_WAIT: rdata_d = idx_in_range ? VAL_W'(ra_data_i) : '0;
      ST_SIFT_LD: carry_d = ra_data_i;
      ST_SIFT_CMP: begin
        cmp_d = sat_add(cmp_q, CMP_PER_LEVEL);
        if (swap) begin
          swp_d   = sat_add(swp_q, SWAP_INC);
          node_d  = sel_w[NW-1:0];
          moved_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      moved_q <= 1'b0;
      swp_q   <= '0;
      cmp_q   <= '0;
    end else begin
      state_q <= state_d;
      moved_q <= moved_d;
      swp_q   <= swp_d;
      cmp_q   <= cmp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    idx_q   <= idx_d;
    val_q   <= val_d;
    size_q  <= size_d;
    node_q  <= node_d;
    carry_q <= carry_d;
    rdata_q <= rdata_d;
  end

  assign rsp_o = '{read_data: rdata_q, swaps: swp_q, compares: cmp_q};

endmodule

`default_nettype wire

@@ rtl/binary_heap_sift_down_core.sv @@
// ----------------------------------------------------------------------------
// binary_heap_sift_down_core
// element store with write, read, counter clear and sift-down requests
// ----------------------------------------------------------------------------
// One request is taken at a time and gives exactly one result beat. A sift
// reads the element at the start node into a carry register and walks down
// at most log2(DEPTH) + 1 levels: each level reads both children through
// the two read ports of the store, then compares and writes back. Each
// promoted child is written to its parent's slot on the way down and, if
// any child moved up, the carried element is written once, where the walk
// stops. A finished result sits in an output register, so a new request is
// taken while the last beat is still waiting downstream. Element entries
// hold nothing defined until written; there is no clearing pass. heap_order
// is written on a port of its own and must only change while the core is
// idle.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_heap_sift_down_core import hsd_pkg::*; #(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // configuration write channel
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic                     cfg_data_i,
  // request channel
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic        [1:0]        req_type_i,
  input  wire logic        [IDX_W-1:0]  index_i,
  input  wire logic signed [VAL_W-1:0]  value_i,
  input  wire logic        [SIZE_W-1:0] heap_size_i,
  // result channel
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed      [VAL_W-1:0]  read_data_o,
  output logic             [CNT_W-1:0]  total_swaps_o,
  output logic             [CNT_W-1:0]  total_compares_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  // heap ordering register, always writable
  order_e heap_order_q, heap_order_d;

  // store port wiring
  logic                         we;
  logic        [AW-1:0]         waddr;
  logic        [ELEM_WIDTH-1:0] wdata;
  logic                         ra_en;
  logic        [AW-1:0]         ra_addr;
  logic signed [ELEM_WIDTH-1:0] ra_data;
  logic                         rb_en;
  logic        [AW-1:0]         rb_addr;
  logic signed [ELEM_WIDTH-1:0] rb_data;

  // result handover from the sequencer
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  // output register
  logic out_valid_q, out_valid_d;
  rsp_t out_q, out_d;

  assign cfg_ready_o  = 1'b1;
  assign heap_order_d = (cfg_valid_i) ? order_e'(cfg_data_i) : heap_order_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_order_q <= ORDER_MAX;
    end else begin
      heap_order_q <= heap_order_d;
    end
  end

  hsd_ctrl #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .index_i      (index_i),
    .value_i      (value_i),
    .heap_size_i  (heap_size_i),
    .heap_order_i (heap_order_q),
    .rsp_valid_o  (rsp_valid),
    .rsp_ready_i  (rsp_ready),
    .rsp_o        (rsp),
    .we_o         (we),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .ra_en_o      (ra_en),
    .ra_addr_o    (ra_addr),
    .ra_data_i    (ra_data),
    .rb_en_o      (rb_en),
    .rb_addr_o    (rb_addr),
    .rb_data_i    (rb_data)
  );

  hsd_mem #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .ra_en_i   (ra_en),
    .ra_addr_i (ra_addr),
    .ra_data_o (ra_data),
    .rb_en_i   (rb_en),
    .rb_addr_i (rb_addr),
    .rb_data_o (rb_data)
  );

  // the output slot takes a new beat when empty or being drained this cycle
  assign rsp_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (rsp_ready) begin
      out_valid_d = rsp_valid;
      if (rsp_valid) begin
        out_d = rsp;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o      = out_valid_q;
  assign read_data_o      = out_q.read_data;
  assign total_swaps_o    = out_q.swaps;
  assign total_compares_o = out_q.compares;

endmodule

`default_nettype wire

@@ rtl/hsd_chk.sv @@
// ----------------------------------------------------------------------------
// hsd_chk
// port-level checks of the heap sift-down core, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module hsd_chk import hsd_pkg::*; (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     cfg_valid_i,
  input wire logic                     cfg_ready_o,
  input wire logic                     cfg_data_i,
  input wire logic                     in_valid_i,
  input wire logic                     in_ready_o,
  input wire logic        [1:0]        req_type_i,
  input wire logic        [IDX_W-1:0]  index_i,
  input wire logic signed [VAL_W-1:0]  value_i,
  input wire logic        [SIZE_W-1:0] heap_size_i,
  input wire logic                     out_valid_o,
  input wire logic                     out_ready_i,
  input wire logic signed [VAL_W-1:0]  read_data_o,
  input wire logic        [CNT_W-1:0]  total_swaps_o,
  input wire logic        [CNT_W-1:0]  total_compares_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_data_o)
      && $stable(total_swaps_o) && $stable(total_compares_o))
    else $error("result beat changed while stalled");

  // one request in flight
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while another is in flight");

  // a result is produced only while no request is being taken
  a_rsp_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without a request in flight");

  // every swap comes with a level of three comparisons
  a_cnt_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> total_compares_o >= total_swaps_o)
    else $error("swap count above compare count");

endmodule

bind binary_heap_sift_down_core hsd_chk u_hsd_chk (.*);

`default_nettype wire
